// ----- hw/rtl/svm_pkg.sv -----
// svm_pkg: shared types and constants for the sample voice mixer
// holds the command item passed from front to back, field widths and state codes
// no dependencies
package svm_pkg;

    localparam int OP_W       = 3;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int IDX_W      = 10;
    localparam int SMP_W      = 16;
    localparam int LEN_W      = 11;
    localparam int PROD_W     = SMP_W + VEL_W + 1;
    // velocity scale is 1/128
    localparam int FRAC_SHIFT = 7;

    localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7fff;
    localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

    typedef enum logic [OP_W-1:0] {
        OP_KEY_ON  = 3'd0,
        OP_KEY_OFF = 3'd1,
        OP_WRITE   = 3'd2,
        OP_LENGTH  = 3'd3,
        OP_TICK    = 3'd4
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [NOTE_W-1:0]        note;
        logic [VEL_W-1:0]         vel;
        logic [IDX_W-1:0]         idx;
        logic signed [SMP_W-1:0]  value;
        logic [LEN_W-1:0]         len;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_WALK
    } bk_state_t;

    typedef struct packed {
        logic walking;
        logic pipe_busy;
    } bk_status_t;

endpackage

// ----- hw/rtl/sample_voice_mixer_top.sv -----
// sample_voice_mixer_top: polyphonic one-shot sample player and mixer
// depends on svm_pkg, svm_front, svm_cmd_queue, svm_back and svm_ram
//
// Items enter through a classifier and a two entry command queue; the back end runs
// them one at a time. Key on, key off, sample writes and length writes are carried out
// as they leave the queue. A tick walks all VOICES notes through a five stage pipeline
// (voice state read, sample read, multiply, scale, saturating add) and then delivers
// its mix; one voice enters the pipeline per cycle, bounded by the single read port
// of the sample memory. A tick waits in the queue while the previous mix has not been
// taken. No clearing pass follows reset; sample words read before they are written
// return unknown values.
module sample_voice_mixer_top
    import svm_pkg::*;
#(
    parameter int VOICES       = 128,
    parameter int SAMPLE_DEPTH = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [OP_W-1:0]         op,
    input  logic [NOTE_W-1:0]       note_number,
    input  logic [VEL_W-1:0]        velocity,
    input  logic [IDX_W-1:0]        sample_index,
    input  logic signed [SMP_W-1:0] sample_value,
    input  logic [LEN_W-1:0]        sample_length,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SMP_W-1:0] mix_sample,
    output logic                    clipped
);

    logic       q_space;
    logic       q_push;
    cmd_t       push_cmd;
    logic       q_valid;
    logic       q_pop;
    cmd_t       q_cmd;
    bk_status_t bk_st;

    svm_front #(.VOICES(VOICES), .SAMPLE_DEPTH(SAMPLE_DEPTH)) u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .note_number   (note_number),
        .velocity      (velocity),
        .sample_index  (sample_index),
        .sample_value  (sample_value),
        .sample_length (sample_length),
        .q_space       (q_space),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    svm_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .space    (q_space),
        .q_valid  (q_valid),
        .pop      (q_pop),
        .q_cmd    (q_cmd)
    );

    svm_back #(.VOICES(VOICES), .SAMPLE_DEPTH(SAMPLE_DEPTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mix_sample (mix_sample),
        .clipped    (clipped),
        .status     (bk_st)
    );

`ifndef ASSERT_OFF
    a_no_pop_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        bk_st.walking |-> !q_pop)
        else $error("command taken from queue during a voice walk");

    a_pipe_only_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        !bk_st.walking |-> !bk_st.pipe_busy)
        else $error("walk pipeline busy outside a walk");

    a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(bk_st.walking))
        else $error("mix result raised without a finished walk");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty command queue");
`endif

endmodule

// ----- hw/rtl/svm_ram.sv -----
// svm_ram: generic single write port, single read port ram with registered read
// no dependencies
module svm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/svm_front.sv -----
// svm_front: accepts input items, drops those that change nothing and builds commands
// depends on svm_pkg
module svm_front
    import svm_pkg::*;
#(
    parameter int VOICES       = 128,
    parameter int SAMPLE_DEPTH = 1024
) (
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          op,
    input  logic [NOTE_W-1:0]        note_number,
    input  logic [VEL_W-1:0]         velocity,
    input  logic [IDX_W-1:0]         sample_index,
    input  logic signed [SMP_W-1:0]  sample_value,
    input  logic [LEN_W-1:0]         sample_length,
    input  logic                     q_space,
    output logic                     q_push,
    output cmd_t                     q_cmd
);

    logic             keep;
    logic             note_ok;
    logic             idx_ok;
    logic [LEN_W-1:0] len_sat;

    assign note_ok = 32'(note_number) < VOICES;
    assign idx_ok  = 32'(sample_index) < SAMPLE_DEPTH;
    assign len_sat = (32'(sample_length) > SAMPLE_DEPTH) ? LEN_W'(SAMPLE_DEPTH) : sample_length;

    always_comb
    begin
        keep = 1'b0;
        unique case (op)
            OP_TICK:                          keep = 1'b1;
            OP_KEY_ON, OP_KEY_OFF, OP_LENGTH: keep = note_ok;
            OP_WRITE:                         keep = note_ok & idx_ok;
            default:                          keep = 1'b0;
        endcase
    end

    assign in_ready = q_space;
    // unused op codes, out of range notes and out of range write indices are taken but never queued
    assign q_push   = in_valid & q_space & keep;

    assign q_cmd.op    = op_t'(op);
    assign q_cmd.note  = note_number;
    assign q_cmd.vel   = velocity;
    assign q_cmd.idx   = sample_index;
    assign q_cmd.value = sample_value;
    assign q_cmd.len   = len_sat;

endmodule

// ----- hw/rtl/svm_cmd_queue.sv -----
// svm_cmd_queue: two entry command queue between front and back
// depends on svm_pkg
module svm_cmd_queue
    import svm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic space,
    output logic q_valid,
    input  logic pop,
    output cmd_t q_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign space   = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hw/rtl/svm_back.sv -----
// svm_back: executes queued commands, walks the voices on a tick and holds the result
// depends on svm_pkg and svm_ram
module svm_back
    import svm_pkg::*;
#(
    parameter int VOICES       = 128,
    parameter int SAMPLE_DEPTH = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  cmd_t                    q_cmd,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SMP_W-1:0] mix_sample,
    output logic                    clipped,
    output bk_status_t              status
);

    localparam int NW        = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW        = $clog2(VOICES + 1);
    localparam int MEM_DEPTH = VOICES * SAMPLE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int VW        = VEL_W + LEN_W;

    bk_state_t state_reg;
    bk_state_t state_next;

    logic [CW-1:0]     walk_cnt_reg;
    logic [VOICES-1:0] active_reg;
    logic [VOICES-1:0] lvalid_reg;

    // voice ram word is {velocity, position}
    logic          v_we;
    logic [NW-1:0] v_waddr;
    logic [VW-1:0] v_wdata;
    logic [VW-1:0] v_rdata;
    logic             l_we;
    logic [LEN_W-1:0] l_rdata;
    logic          s_we;
    logic [AW-1:0] s_waddr;
    logic [AW-1:0] s_raddr;
    logic [SMP_W-1:0] s_rdata;

    logic          act_we;
    logic [NW-1:0] act_idx;
    logic          act_val;
    logic          walk_start;
    logic          issue;
    logic          finish;

    // walk pipeline
    logic                       s1_v_reg;
    logic [NW-1:0]              s1_note_reg;
    logic                       s2_v_reg;
    logic [VEL_W-1:0]           s2_vel_reg;
    logic                       s3_v_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       s4_v_reg;
    logic signed [SMP_W-1:0]    part_reg;
    logic signed [SMP_W-1:0]    sum_reg;
    logic signed [SMP_W-1:0]    sum_next;
    logic                       clip_reg;
    logic                       clip_next;

    logic                       out_valid_reg;
    logic signed [SMP_W-1:0]    mix_reg;
    logic                       clipped_reg;

    logic [VEL_W-1:0]         s1_vel;
    logic [LEN_W-1:0]         s1_pos;
    logic [LEN_W-1:0]         s1_len;
    logic                     s1_act;
    logic                     play;
    logic                     stop;
    logic                     pipe_busy;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [SMP_W:0]    sum_wide;
    logic                     ovf;

    svm_ram #(.WIDTH(VW), .DEPTH(VOICES)) u_voice_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (walk_cnt_reg[NW-1:0]),
        .rdata (v_rdata)
    );

    svm_ram #(.WIDTH(LEN_W), .DEPTH(VOICES)) u_len_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (q_cmd.note[NW-1:0]),
        .wdata (q_cmd.len),
        .raddr (walk_cnt_reg[NW-1:0]),
        .rdata (l_rdata)
    );

    svm_ram #(.WIDTH(SMP_W), .DEPTH(MEM_DEPTH)) u_sample_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (q_cmd.value),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // stage 1: voice state is back from ram, decide play or stop
    assign s1_vel = v_rdata[VW-1:LEN_W];
    assign s1_pos = v_rdata[LEN_W-1:0];
    assign s1_len = lvalid_reg[s1_note_reg] ? l_rdata : '0;
    assign s1_act = active_reg[s1_note_reg];
    assign play   = s1_v_reg & s1_act & (s1_pos < s1_len);
    assign stop   = s1_v_reg & s1_act & ~(s1_pos < s1_len);

    assign s_waddr = AW'(32'(q_cmd.note) * 32'(SAMPLE_DEPTH) + 32'(q_cmd.idx));
    assign s_raddr = AW'(32'(s1_note_reg) * 32'(SAMPLE_DEPTH) + 32'(s1_pos));

    assign pipe_busy = s1_v_reg | s2_v_reg | s3_v_reg | s4_v_reg;

    // truncate toward zero: bias negative products before the shift
    assign prod_adj = prod_reg + (prod_reg[PROD_W-1] ? PROD_W'((1 << FRAC_SHIFT) - 1) : '0);

    assign sum_wide = {sum_reg[SMP_W-1], sum_reg} + {part_reg[SMP_W-1], part_reg};
    assign ovf      = sum_wide[SMP_W] ^ sum_wide[SMP_W-1];

    always_comb
    begin
        sum_next  = sum_reg;
        clip_next = clip_reg;
        if (s4_v_reg)
        begin
            if (ovf)
            begin
                sum_next  = sum_wide[SMP_W] ? SMP_MIN : SMP_MAX;
                clip_next = 1'b1;
            end
            else
            begin
                sum_next = sum_wide[SMP_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        v_we       = 1'b0;
        v_waddr    = q_cmd.note[NW-1:0];
        v_wdata    = {q_cmd.vel, LEN_W'(0)};
        l_we       = 1'b0;
        s_we       = 1'b0;
        act_we     = 1'b0;
        act_idx    = q_cmd.note[NW-1:0];
        act_val    = 1'b0;
        walk_start = 1'b0;
        issue      = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                // a tick waits until the previous result has been taken
                if (q_valid && (q_cmd.op != OP_TICK || !out_valid_reg))
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.op)
                        OP_KEY_ON:
                        begin
                            v_we    = 1'b1;
                            act_we  = 1'b1;
                            act_val = 1'b1;
                        end
                        OP_KEY_OFF:
                        begin
                            v_we    = 1'b1;
                            act_we  = 1'b1;
                            act_val = 1'b0;
                        end
                        OP_WRITE:  s_we = 1'b1;
                        OP_LENGTH: l_we = 1'b1;
                        OP_TICK:
                        begin
                            walk_start = 1'b1;
                            state_next = BK_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            BK_WALK:
            begin
                issue = (walk_cnt_reg < CW'(VOICES));
                if (play)
                begin
                    v_we    = 1'b1;
                    v_waddr = s1_note_reg;
                    v_wdata = {s1_vel, s1_pos + LEN_W'(1)};
                end
                if (stop)
                begin
                    act_we  = 1'b1;
                    act_idx = s1_note_reg;
                    act_val = 1'b0;
                end
                if (!issue && !pipe_busy)
                begin
                    finish     = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            walk_cnt_reg  <= '0;
            active_reg    <= '0;
            lvalid_reg    <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            sum_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (act_we)
            begin
                active_reg[act_idx] <= act_val;
            end
            if (l_we)
            begin
                lvalid_reg[q_cmd.note[NW-1:0]] <= 1'b1;
            end
            if (walk_start)
            begin
                walk_cnt_reg <= '0;
            end
            else if (issue)
            begin
                walk_cnt_reg <= walk_cnt_reg + CW'(1);
            end
            s1_v_reg <= issue;
            s2_v_reg <= play;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            if (walk_start)
            begin
                sum_reg  <= '0;
                clip_reg <= 1'b0;
            end
            else
            begin
                sum_reg  <= sum_next;
                clip_reg <= clip_next;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_note_reg <= walk_cnt_reg[NW-1:0];
        s2_vel_reg  <= s1_vel;
        prod_reg    <= $signed(s_rdata) * $signed({1'b0, s2_vel_reg});
        part_reg    <= prod_adj[FRAC_SHIFT +: SMP_W];
        if (finish)
        begin
            mix_reg     <= sum_reg;
            clipped_reg <= clip_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign mix_sample       = mix_reg;
    assign clipped          = clipped_reg;
    assign status.walking   = (state_reg == BK_WALK);
    assign status.pipe_busy = pipe_busy;

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking testbench for sample_voice_mixer_top
// predicts each tick's mix from its own copy of the voice state and compares results
// depends on svm_pkg and sample_voice_mixer_top
`timescale 1ns / 1ps

module tb;
    import svm_pkg::*;

    localparam int VOICES         = 128;
    localparam int SAMPLE_DEPTH   = 1024;
    localparam int ITEMS_TOTAL    = 1100;
    localparam int CALM_ITEMS     = 150;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int LIMIT_CYCLES   = 1000000;

    // op codes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        logic signed [SMP_W-1:0] mix;
        logic                    clip;
    } mix_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [OP_W-1:0]         op;
    logic [NOTE_W-1:0]       note_number;
    logic [VEL_W-1:0]        velocity;
    logic [IDX_W-1:0]        sample_index;
    logic signed [SMP_W-1:0] sample_value;
    logic [LEN_W-1:0]        sample_length;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [SMP_W-1:0] mix_sample;
    logic                    clipped;

    // predicted voice state
    logic signed [SMP_W-1:0] pcm_words   [VOICES*SAMPLE_DEPTH];
    bit                      pcm_written [VOICES*SAMPLE_DEPTH];
    logic [LEN_W-1:0]        note_len    [VOICES];
    logic [LEN_W-1:0]        note_pos    [VOICES];
    logic [VEL_W-1:0]        note_vel    [VOICES];
    bit                      note_on     [VOICES];

    mix_result_t mix_expect_q[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  cycle_cnt  = 0;
    bit  calm       = 1'b0;
    bit  tx_quiet   = 1'b0;
    bit  rx_quiet   = 1'b0;
    bit  hold_req   = 1'b0;

    sample_voice_mixer_top #(
        .VOICES       (VOICES),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .note_number   (note_number),
        .velocity      (velocity),
        .sample_index  (sample_index),
        .sample_value  (sample_value),
        .sample_length (sample_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mix_sample    (mix_sample),
        .clipped       (clipped)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // apply one accepted item to the predicted voice state
    task automatic predict_voice_op(
        input logic [OP_W-1:0]         o,
        input logic [NOTE_W-1:0]       nn,
        input logic [VEL_W-1:0]        vv,
        input logic [IDX_W-1:0]        ii,
        input logic signed [SMP_W-1:0] sv,
        input logic [LEN_W-1:0]        ll
    );
        int          sum;
        int          part;
        int          addr;
        mix_result_t res;
        sum  = 0;
        res.clip = 1'b0;
        addr = int'(nn) * SAMPLE_DEPTH + int'(ii);
        case (o)
            OP_KEY_ON:
            begin
                note_vel[nn] = vv;
                note_pos[nn] = '0;
                note_on[nn]  = 1'b1;
            end
            OP_KEY_OFF:
            begin
                note_vel[nn] = vv;
                note_pos[nn] = '0;
                note_on[nn]  = 1'b0;
            end
            OP_WRITE:
            begin
                pcm_words[addr]   = sv;
                pcm_written[addr] = 1'b1;
            end
            OP_LENGTH:
            begin
                note_len[nn] = (ll > SAMPLE_DEPTH) ? LEN_W'(SAMPLE_DEPTH) : ll;
            end
            OP_TICK:
            begin
                for (int n = 0; n < VOICES; n++)
                begin
                    if (note_on[n])
                    begin
                        if (note_pos[n] >= note_len[n])
                        begin
                            note_pos[n] = '0;
                            note_on[n]  = 1'b0;
                        end
                        else
                        begin
                            // signed divide truncates toward zero
                            part = (int'(pcm_words[n*SAMPLE_DEPTH + note_pos[n]])
                                    * int'(note_vel[n])) / 128;
                            sum += part;
                            if (sum > int'(SMP_MAX))
                            begin
                                sum      = int'(SMP_MAX);
                                res.clip = 1'b1;
                            end
                            else if (sum < int'(SMP_MIN))
                            begin
                                sum      = int'(SMP_MIN);
                                res.clip = 1'b1;
                            end
                            note_pos[n] = note_pos[n] + 1'b1;
                        end
                    end
                end
                res.mix = sum[SMP_W-1:0];
                mix_expect_q.push_back(res);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_item(
        input logic [OP_W-1:0]         o,
        input logic [NOTE_W-1:0]       nn,
        input logic [VEL_W-1:0]        vv,
        input logic [IDX_W-1:0]        ii,
        input logic signed [SMP_W-1:0] sv,
        input logic [LEN_W-1:0]        ll
    );
        bit took;
        if (!calm && !tx_quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= o;
        note_number   <= nn;
        velocity      <= vv;
        sample_index  <= ii;
        sample_value  <= sv;
        sample_length <= ll;
        // inputs only move at the rising edge, so mid-cycle ready is the edge value
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        predict_voice_op(o, nn, vv, ii, sv, ll);
        items_sent++;
        if ($urandom_range(0, 39) == 0)
            tx_quiet = !tx_quiet;
    endtask

    function automatic logic signed [SMP_W-1:0] rnd_pcm();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
        return SMP_W'($urandom);
    endfunction

    function automatic logic [NOTE_W-1:0] rnd_note();
        if ($urandom_range(0, 1) == 0)
            return NOTE_W'($urandom_range(0, 7));
        return NOTE_W'($urandom);
    endfunction

    function automatic logic [OP_W-1:0] OP_Spare_pick();
        case ($urandom_range(0, 2))
            0:       return OP_SPARE_5;
            1:       return OP_SPARE_6;
            default: return OP_SPARE_7;
        endcase
    endfunction

    // a voice must never play a word that was never written: fill it or silence it
    task automatic send_tick();
        int addr;
        for (int n = 0; n < VOICES; n++)
        begin
            addr = n * SAMPLE_DEPTH + int'(note_pos[n]);
            if (note_on[n] && note_pos[n] < note_len[n] && !pcm_written[addr])
            begin
                if ($urandom_range(0, 1))
                    send_item(OP_WRITE, NOTE_W'(n), VEL_W'($urandom),
                              note_pos[n][IDX_W-1:0], rnd_pcm(), LEN_W'($urandom));
                else
                    send_item(OP_KEY_OFF, NOTE_W'(n), VEL_W'($urandom),
                              IDX_W'($urandom), rnd_pcm(), LEN_W'($urandom));
            end
        end
        send_item(OP_TICK, NOTE_W'($urandom), VEL_W'($urandom), IDX_W'($urandom),
                  rnd_pcm(), LEN_W'($urandom));
    endtask

    // load a short one-shot into a note and start it
    task automatic program_note(input logic [NOTE_W-1:0] nn, input int len,
                                input logic [VEL_W-1:0] vv);
        send_item(OP_LENGTH, nn, VEL_W'($urandom), IDX_W'($urandom), rnd_pcm(),
                  LEN_W'(len));
        for (int i = 0; i < len; i++)
            send_item(OP_WRITE, nn, VEL_W'($urandom), IDX_W'(i), rnd_pcm(),
                      LEN_W'($urandom));
        send_item(OP_KEY_ON, nn, vv, IDX_W'($urandom), rnd_pcm(), LEN_W'($urandom));
    endtask

    task automatic test_directed();
        send_item(OP_LENGTH, 7'd0, 7'd0, 10'd0, 16'sd0, 11'd1);
        send_item(OP_WRITE, 7'd0, 7'd0, 10'd0, SMP_MAX, 11'd0);
        send_item(OP_LENGTH, 7'd1, 7'd0, 10'd0, 16'sd0, 11'd2);
        send_item(OP_WRITE, 7'd1, 7'd0, 10'd0, SMP_MAX, 11'd0);
        send_item(OP_WRITE, 7'd1, 7'd0, 10'd1, SMP_MIN, 11'd0);
        send_item(OP_KEY_ON, 7'd0, 7'd127, 10'd0, 16'sd0, 11'd0);
        send_item(OP_KEY_ON, 7'd1, 7'd127, 10'd0, 16'sd0, 11'd0);
        // positive overflow, then note 0 runs off its end
        send_tick();
        send_tick();
        // length past the store depth saturates
        send_item(OP_LENGTH, 7'd127, 7'd0, 10'd1023, 16'sd0, 11'd2047);
        send_item(OP_WRITE, 7'd127, 7'd0, 10'd1023, -16'sd1, 11'd0);
        send_item(OP_WRITE, 7'd127, 7'd0, 10'd0, -16'sd1, 11'd0);
        // small negative product truncates to zero
        send_item(OP_KEY_ON, 7'd127, 7'd1, 10'd0, 16'sd0, 11'd0);
        // zero-length sample stops on its first tick
        send_item(OP_LENGTH, 7'd2, 7'd0, 10'd0, 16'sd0, 11'd0);
        send_item(OP_KEY_ON, 7'd2, 7'd0, 10'd0, 16'sd0, 11'd0);
        send_tick();
        send_item(OP_SPARE_5, 7'd127, 7'd127, 10'd1023, SMP_MIN, 11'd2047);
        send_item(OP_SPARE_6, 7'd0, 7'd0, 10'd0, SMP_MAX, 11'd0);
        send_item(OP_SPARE_7, 7'd127, 7'd127, 10'd1023, -16'sd1, 11'd2047);
        send_item(OP_KEY_OFF, 7'd127, 7'd0, 10'd0, 16'sd0, 11'd0);
        // negative overflow
        send_item(OP_WRITE, 7'd0, 7'd0, 10'd0, SMP_MIN, 11'd0);
        send_item(OP_WRITE, 7'd1, 7'd0, 10'd0, SMP_MIN, 11'd0);
        send_item(OP_KEY_ON, 7'd0, 7'd127, 10'd0, 16'sd0, 11'd0);
        send_item(OP_KEY_ON, 7'd1, 7'd127, 10'd0, 16'sd0, 11'd0);
        send_tick();
    endtask

    // receiver stops taking mixes while ticks keep coming, so the input backs up
    task automatic test_stall_fill();
        hold_req = 1'b1;
        program_note(7'd5, 3, 7'd100);
        for (int i = 0; i < 8; i++)
            send_tick();
    endtask

    task automatic test_random_mix(input int upto);
        int pick;
        while (items_sent < upto)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_tick();
            else if (pick < 55)
                program_note(rnd_note(), ($urandom_range(0, 9) == 0) ? 0
                             : $urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 6),
                             VEL_W'($urandom));
            else if (pick < 63)
                send_item(OP_KEY_ON, rnd_note(), VEL_W'($urandom), IDX_W'($urandom),
                          rnd_pcm(), LEN_W'($urandom));
            else if (pick < 73)
                send_item(OP_KEY_OFF, rnd_note(), VEL_W'($urandom), IDX_W'($urandom),
                          rnd_pcm(), LEN_W'($urandom));
            else if (pick < 83)
                send_item(OP_WRITE, rnd_note(), VEL_W'($urandom), IDX_W'($urandom),
                          rnd_pcm(), LEN_W'($urandom));
            else if (pick < 91)
                send_item(OP_LENGTH, rnd_note(), VEL_W'($urandom), IDX_W'($urandom),
                          rnd_pcm(), LEN_W'($urandom_range(0, 2047)));
            else if (pick < 95)
                send_item(OP_Spare_pick(), NOTE_W'($urandom), VEL_W'($urandom),
                          IDX_W'($urandom), rnd_pcm(), LEN_W'($urandom));
            else
                send_tick();
        end
    endtask

    // result side: random stall bursts, quiet stretches, and one long hold-off
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && !rx_quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            if ($urandom_range(0, 49) == 0)
                rx_quiet = !rx_quiet;
        end
    end

    // outputs only move at the rising edge, so mid-cycle values are what the edge takes
    always @(negedge clk)
    begin : mix_check
        mix_result_t want;
        bit          have;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            have = (mix_expect_q.size() != 0);
            if (have)
                want = mix_expect_q.pop_front();
            if (!have || want.mix !== mix_sample || want.clip !== clipped)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    if (have)
                        $display("mix mismatch: expected %0d clip %0b, got %0d clip %0b",
                                 want.mix, want.clip, mix_sample, clipped);
                    else
                        $display("mix mismatch: none expected, got %0d clip %0b",
                                 mix_sample, clipped);
                end
            end
        end
    end

    initial
    begin
        for (int n = 0; n < VOICES; n++)
        begin
            note_len[n] = '0;
            note_pos[n] = '0;
            note_vel[n] = '0;
            note_on[n]  = 1'b0;
        end
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        op            <= '0;
        note_number   <= '0;
        velocity      <= '0;
        sample_index  <= '0;
        sample_value  <= '0;
        sample_length <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_stall_fill();
        test_random_mix(ITEMS_TOTAL - CALM_ITEMS);
        calm = 1'b1;
        test_random_mix(ITEMS_TOTAL);
        in_valid <= 1'b0;

        while (mix_expect_q.size() != 0)
            @(posedge clk);
        repeat (VOICES + 16) @(posedge clk);
        if (mismatches == 0 && mix_expect_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/svm_pkg.sv
hw/rtl/svm_ram.sv
hw/rtl/svm_front.sv
hw/rtl/svm_cmd_queue.sv
hw/rtl/svm_back.sv
hw/rtl/sample_voice_mixer_top.sv
tb/sv/tb.sv
